// File: hw/rtl/mtst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtst_pkg
// Shared types and constants for the multitouch slot frame tracker.
// ----------------------------------------------------------------------------
package mtst_pkg;

    localparam int SLOTS     = 10;
    localparam int KEY_DEPTH = 16;

    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int KCNT_W  = $clog2(KEY_DEPTH + 1);
    localparam int KEY_AW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int IDX_W   = (KCNT_W > SLOT_W) ? KCNT_W : SLOT_W;

    localparam logic [TYPE_W-1:0] EVT_SYN = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] EVT_KEY = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] EVT_ABS = TYPE_W'(3);

    localparam logic [CODE_W-1:0] SYNC_REPORT  = CODE_W'(0);
    localparam logic [CODE_W-1:0] SYNC_DROPPED = CODE_W'(3);
    localparam logic [CODE_W-1:0] AXIS_SLOT    = CODE_W'('h2F);
    localparam logic [CODE_W-1:0] AXIS_X       = CODE_W'('h35);
    localparam logic [CODE_W-1:0] AXIS_Y       = CODE_W'('h36);
    localparam logic [CODE_W-1:0] AXIS_TRACK   = CODE_W'('h39);

    localparam logic REC_KEY  = 1'b0;
    localparam logic REC_SLOT = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0]       ev_type;
        logic [CODE_W-1:0]       ev_code;
        logic signed [VAL_W-1:0] ev_value;
    } t_ev;

    typedef struct packed {
        logic                    record_kind;
        logic [SLOT_W-1:0]       slot_index;
        logic [CODE_W-1:0]       key_code;
        logic signed [VAL_W-1:0] key_value;
        logic                    finger_present;
        logic signed [VAL_W-1:0] track_id;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic                    last;
    } t_rec;

    typedef struct packed {
        logic             accept;
        logic             key_ld;
        logic             slot_ld;
        logic             last;
        logic             clr_keys;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              is_report;
        logic              out_free;
        logic [KCNT_W-1:0] key_cnt;
    } t_sts;

endpackage

// File: hw/rtl/multitouch_slot_frame_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitouch_slot_frame_tracker_unit
// Tracks multitouch protocol B slots from input events and emits a frame of
// buffered key records and slot records on each report sync.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall   i_in_req  (t_ev)
//   out       output     o_out_valid / i_out_stall o_out_rec (t_rec)
//
// An event is accepted while idle. A report sync then reads and emits each
// buffered key (S_KRD, S_KOUT), then each slot record (S_SOUT), through the
// single key buffer read port and one output record register. Reset is
// synchronous and needs no clearing pass. Output stalls hold the sequencer,
// and no request is taken until the frame's last record is loaded.
// ----------------------------------------------------------------------------
module multitouch_slot_frame_tracker_unit
    import mtst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_ev  i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rec o_out_rec
);

    t_cmd cmd;
    t_sts sts;

    mtst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rec   (o_out_rec)
    );

endmodule

// File: hw/rtl/mtst_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtst_dpath
// Slot state registers, key buffer memory and the output record register.
// ----------------------------------------------------------------------------
module mtst_dpath
    import mtst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ev  i_in_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rec o_out_rec
);

    logic signed [VAL_W-1:0] r_track [SLOTS];
    logic                    r_pres  [SLOTS];
    logic signed [VAL_W-1:0] r_x     [SLOTS];
    logic signed [VAL_W-1:0] r_y     [SLOTS];
    logic [SLOT_W-1:0]       r_sel;
    logic [KCNT_W-1:0]       r_key_cnt;

    logic [CODE_W-1:0]       r_kmem_code [KEY_DEPTH];
    logic signed [VAL_W-1:0] r_kmem_val  [KEY_DEPTH];
    logic [CODE_W-1:0]       r_kcode_rd;
    logic signed [VAL_W-1:0] r_kval_rd;

    logic r_out_valid;
    t_rec r_out_rec;

    logic              is_abs;
    logic              is_key;
    logic              is_syn;
    logic              is_drop;
    logic [SLOT_W-1:0] n_sel;
    logic [SLOT_W-1:0] rd_slot;
    logic              out_free;

    assign is_abs  = i_cmd.accept && (i_in_req.ev_type == EVT_ABS);
    assign is_key  = i_cmd.accept && (i_in_req.ev_type == EVT_KEY);
    assign is_syn  = i_in_req.ev_type == EVT_SYN;
    assign is_drop = i_cmd.accept && is_syn && (i_in_req.ev_code == SYNC_DROPPED);
    assign rd_slot = i_cmd.idx[SLOT_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_in_req.ev_value[VAL_W-1]) begin
            n_sel = '0;
        end else if (i_in_req.ev_value >= VAL_W'(SLOTS)) begin
            n_sel = SLOT_W'(SLOTS - 1);
        end else begin
            n_sel = i_in_req.ev_value[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_track[s] <= '1;
                r_pres[s]  <= 1'b0;
                r_x[s]     <= '0;
                r_y[s]     <= '0;
            end
        end else if (is_drop) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_track[s] <= '1;
                r_pres[s]  <= 1'b0;
                r_x[s]     <= '0;
                r_y[s]     <= '0;
            end
        end else if (is_abs) begin
            case (i_in_req.ev_code)
                AXIS_SLOT: begin
                    r_sel <= n_sel;
                end
                AXIS_TRACK: begin
                    r_track[r_sel] <= i_in_req.ev_value;
                    r_pres[r_sel]  <= (i_in_req.ev_value != '1);
                end
                AXIS_X: begin
                    r_x[r_sel] <= i_in_req.ev_value;
                end
                AXIS_Y: begin
                    r_y[r_sel] <= i_in_req.ev_value;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_cnt <= '0;
        end else if (is_drop || i_cmd.clr_keys) begin
            r_key_cnt <= '0;
        end else if (is_key && (r_key_cnt < KCNT_W'(KEY_DEPTH))) begin
            r_key_cnt <= KCNT_W'(r_key_cnt + KCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_key && (r_key_cnt < KCNT_W'(KEY_DEPTH))) begin
            r_kmem_code[r_key_cnt[KEY_AW-1:0]] <= i_in_req.ev_code;
            r_kmem_val[r_key_cnt[KEY_AW-1:0]]  <= i_in_req.ev_value;
        end
        r_kcode_rd <= r_kmem_code[i_cmd.idx[KEY_AW-1:0]];
        r_kval_rd  <= r_kmem_val[i_cmd.idx[KEY_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.key_ld || i_cmd.slot_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_out_rec.record_kind    <= REC_KEY;
            r_out_rec.slot_index     <= '0;
            r_out_rec.key_code       <= r_kcode_rd;
            r_out_rec.key_value      <= r_kval_rd;
            r_out_rec.finger_present <= 1'b0;
            r_out_rec.track_id       <= '0;
            r_out_rec.pos_x          <= '0;
            r_out_rec.pos_y          <= '0;
            r_out_rec.last           <= 1'b0;
        end else if (i_cmd.slot_ld) begin
            r_out_rec.record_kind    <= REC_SLOT;
            r_out_rec.slot_index     <= rd_slot;
            r_out_rec.key_code       <= '0;
            r_out_rec.key_value      <= '0;
            r_out_rec.finger_present <= r_pres[rd_slot];
            r_out_rec.track_id       <= r_track[rd_slot];
            r_out_rec.pos_x          <= r_x[rd_slot];
            r_out_rec.pos_y          <= r_y[rd_slot];
            r_out_rec.last           <= i_cmd.last;
        end
    end

    assign o_sts.is_report = is_syn && (i_in_req.ev_code == SYNC_REPORT);
    assign o_sts.out_free  = out_free;
    assign o_sts.key_cnt   = r_key_cnt;
    assign o_out_valid     = r_out_valid;
    assign o_out_rec       = r_out_rec;

endmodule

// File: hw/rtl/mtst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtst_ctrl
// Sequencer that accepts events and walks the records of a report frame.
// ----------------------------------------------------------------------------
module mtst_ctrl
    import mtst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KRD  = 2'd1;
    localparam logic [1:0] S_KOUT = 2'd2;
    localparam logic [1:0] S_SOUT = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             key_done;
    logic             slot_done;

    assign key_done  = IDX_W'(r_idx + IDX_W'(1)) == IDX_W'(i_sts.key_cnt);
    assign slot_done = r_idx == IDX_W'(SLOTS - 1);

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd.accept   = 1'b0;
        o_cmd.key_ld   = 1'b0;
        o_cmd.slot_ld  = 1'b0;
        o_cmd.last     = 1'b0;
        o_cmd.clr_keys = 1'b0;
        o_cmd.idx      = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_report) begin
                        n_idx = '0;
                        if (i_sts.key_cnt == '0) begin
                            n_state = S_SOUT;
                        end else begin
                            n_state = S_KRD;
                        end
                    end
                end
            end
            S_KRD: begin
                n_state = S_KOUT;
            end
            S_KOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.key_ld = 1'b1;
                    if (key_done) begin
                        o_cmd.clr_keys = 1'b1;
                        n_idx          = '0;
                        n_state        = S_SOUT;
                    end else begin
                        n_idx   = IDX_W'(r_idx + IDX_W'(1));
                        n_state = S_KRD;
                    end
                end
            end
            S_SOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.slot_ld = 1'b1;
                    o_cmd.last    = slot_done;
                    if (slot_done) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = IDX_W'(r_idx + IDX_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule
